// ===== hdl/bgi_pkg.sv =====
// Package: types and constants for the bilinear grid interpolator.
package bgi_pkg;

  localparam int MAX_X_POINTS = 64;
  localparam int MAX_Y_POINTS = 64;
  localparam int XW = $clog2(MAX_X_POINTS);
  localparam int YW = $clog2(MAX_Y_POINTS);
  localparam int ZW = XW + YW;
  localparam int PW = 7;

  localparam logic [1:0] OP_WX = 2'd0;
  localparam logic [1:0] OP_WY = 2'd1;
  localparam logic [1:0] OP_WZ = 2'd2;
  localparam logic [1:0] OP_Q  = 2'd3;

  localparam logic CFG_XP = 1'b0;
  localparam logic CFG_YP = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } bgi_in_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               in_range;
  } bgi_out_t;

  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_RD0W, S_RANGE, S_XS, S_XSW, S_YS, S_YSW,
    S_CX, S_CXW, S_CY, S_CYW, S_DX, S_DXW, S_DY, S_DYW,
    S_Z0, S_Z1, S_Z2, S_Z3, S_Z4, S_B1, S_B2, S_B3, S_OUT
  } state_t;

endpackage

// ===== hdl/bgi_div.sv =====
// Restoring divider: 17-bit quotient of (num<<16)/den, one bit per cycle.
module bgi_div import bgi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [16:0] quot
);
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r;
  logic [16:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [33:0] sh;
  logic [34:0] dif;

  always_comb begin
    sh = {rem_r[32:0], 1'b0};
    dif = {1'b0, sh} - {2'b0, den_r};
    rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = {1'b0, req.num};
      q_nxt = '0; cnt_nxt = 5'd16; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!dif[34]) begin
        rem_nxt = dif[33:0]; q_nxt = {q_r[15:0], 1'b1};
      end else begin
        rem_nxt = sh; q_nxt = {q_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  // each of the 16 steps shifts in one of the 16 zero bits of num<<16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; q_r <= q_nxt;
    if (req.start) den_r <= req.den;
  end

  assign done = done_r;
  assign quot = q_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 5'd0) else $error("busy with zero count");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("start lost");
endmodule

// ===== hdl/bilinear_grid_interpolator.sv =====
// Top level: bilinear interpolation over x/y grids and z table in RAM.
//  channel | ports                        | handshake
//  input   | in_req, start, busy          | start && !busy
//  result  | out_res, out_strobe          | one-cycle strobe
//  config  | cfg_valid/ready/index/data   | valid && ready
// A write holds busy through the single S_OUT state. A query inside the grid holds
// busy through a range check, a binary search per axis, cell reads, two waits on
// one shared 16-step divider, 4 z reads and 3 blends; one outside ends after the
// range check. A query's result strobe comes in the same cycle that busy falls.
// Reset is synchronous; it clears control only, memories stay undefined. The
// receiver cannot stall; config is always ready.
module bilinear_grid_interpolator import bgi_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bgi_in_t        in_req,
  output logic           out_strobe,
  output bgi_out_t       out_res,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [0:0]     cfg_index,
  input  logic [PW-1:0]  cfg_data
);
  logic [31:0] xg [MAX_X_POINTS];
  logic [31:0] yg [MAX_Y_POINTS];
  logic [31:0] zt [MAX_X_POINTS*MAX_Y_POINTS];
  logic [31:0] xrd_r, yrd_r, zrd_r;

  state_t st_r, st_nxt;
  logic [PW-1:0] xp_r, yp_r;
  bgi_in_t req_r;
  logic [XW-1:0] xa, xlo_r, xlo_nxt, xhi_r, xhi_nxt;
  logic [YW-1:0] ya, ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic [ZW-1:0] za;
  logic signed [31:0] gl_r, gl_nxt, gh_r, gh_nxt;
  logic signed [31:0] c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt, c3_r, c3_nxt;
  logic signed [31:0] r1_r, r1_nxt, r2_r, r2_nxt;
  logic [16:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic oor_r, oor_nxt;
  logic strobe_nxt, strobe_r;
  bgi_out_t res_nxt, res_r;
  div_req_t dreq;
  logic ddone;
  logic [16:0] dq;
  logic signed [32:0] qn, qd;
  logic signed [31:0] ba, bb, bres;
  logic [16:0] bt;
  logic signed [49:0] bsum;
  logic [XW-1:0] xmid;
  logic [YW-1:0] ymid;
  logic [XW:0] xs;
  logic [YW:0] ys;
  logic [16:0] tdiv;
  logic [PW-1:0] xpc, ypc;
  logic signed [31:0] qv;
  logic [ZW-1:0] zrow;

  always_comb begin
    xpc = cfg_data < PW'(2) ? PW'(2) :
          (cfg_data > PW'(MAX_X_POINTS) ? PW'(MAX_X_POINTS) : cfg_data);
    ypc = cfg_data < PW'(2) ? PW'(2) :
          (cfg_data > PW'(MAX_Y_POINTS) ? PW'(MAX_Y_POINTS) : cfg_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xp_r <= PW'(MAX_X_POINTS); yp_r <= PW'(MAX_Y_POINTS);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_XP) xp_r <= xpc;
      else yp_r <= ypc;
    end
  end
  assign cfg_ready = 1'b1;

  assign xs = {1'b0, xlo_r} + {1'b0, xhi_r} + 1'b1;
  assign ys = {1'b0, ylo_r} + {1'b0, yhi_r} + 1'b1;
  assign xmid = xs[XW:1];
  assign ymid = ys[YW:1];

  // blend unit
  always_comb begin
    ba = c0_r; bb = c1_r; bt = tx_r;
    case (st_r)
      S_B2: begin ba = c2_r; bb = c3_r; bt = tx_r; end
      S_B3: begin ba = r1_r; bb = r2_r; bt = ty_r; end
      default: ;
    endcase
    bsum = $signed({1'b0, 17'h10000 - bt}) * ba + $signed({1'b0, bt}) * bb;
    bres = bsum[47:16];
  end

  assign qv = (st_r == S_DX || st_r == S_CX || st_r == S_CXW || st_r == S_DXW ||
               st_r == S_CY) ? req_r.query_x : req_r.query_y;
  assign qn = {qv[31], qv} - {gl_r[31], gl_r};
  assign qd = {gh_r[31], gh_r} - {gl_r[31], gl_r};
  assign tdiv = (qd <= 0 || qn <= 0) ? 17'd0 : (qn >= qd ? 17'h10000 : dq);

  assign zrow = ZW'(yp_r) * ZW'(xlo_r);

  always_comb begin
    st_nxt = st_r;
    xlo_nxt = xlo_r; xhi_nxt = xhi_r; ylo_nxt = ylo_r; yhi_nxt = yhi_r;
    gl_nxt = gl_r; gh_nxt = gh_r; oor_nxt = oor_r;
    c0_nxt = c0_r; c1_nxt = c1_r; c2_nxt = c2_r; c3_nxt = c3_r;
    r1_nxt = r1_r; r2_nxt = r2_r; tx_nxt = tx_r; ty_nxt = ty_r;
    strobe_nxt = 1'b0; res_nxt = res_r;
    xa = '0; ya = '0; za = '0;
    dreq = '0;
    case (st_r)
      S_IDLE: if (start) st_nxt = (in_req.op == OP_Q) ? S_RD0 : S_OUT;
      S_RD0: begin xa = '0; ya = '0; st_nxt = S_RD0W; end
      S_RD0W: begin
        xa = XW'(xp_r - PW'(1)); ya = YW'(yp_r - PW'(1));
        oor_nxt = ($signed(req_r.query_x) < $signed(xrd_r)) ||
                  ($signed(req_r.query_y) < $signed(yrd_r));
        st_nxt = S_RANGE;
      end
      S_RANGE: begin
        if (oor_r || $signed(req_r.query_x) > $signed(xrd_r) ||
            $signed(req_r.query_y) > $signed(yrd_r)) begin
          res_nxt = '0; strobe_nxt = 1'b1; st_nxt = S_IDLE;
        end else begin
          xlo_nxt = '0; xhi_nxt = XW'(xp_r - PW'(2));
          ylo_nxt = '0; yhi_nxt = YW'(yp_r - PW'(2));
          st_nxt = S_XS;
        end
      end
      S_XS: begin
        xa = xmid;
        st_nxt = (xlo_r < xhi_r) ? S_XSW : S_YS;
      end
      S_XSW: begin
        if ($signed(xrd_r) <= $signed(req_r.query_x)) xlo_nxt = xmid;
        else xhi_nxt = xmid - XW'(1);
        st_nxt = S_XS;
      end
      S_YS: begin
        ya = ymid;
        st_nxt = (ylo_r < yhi_r) ? S_YSW : S_CX;
      end
      S_YSW: begin
        if ($signed(yrd_r) <= $signed(req_r.query_y)) ylo_nxt = ymid;
        else yhi_nxt = ymid - YW'(1);
        st_nxt = S_YS;
      end
      S_CX: begin xa = xlo_r; st_nxt = S_CXW; end
      S_CXW: begin gl_nxt = xrd_r; xa = xlo_r + XW'(1); st_nxt = S_DX; end
      S_DX: begin
        gh_nxt = xrd_r; st_nxt = S_DXW;
      end
      S_DXW: begin
        dreq.start = 1'b1; dreq.num = qn; dreq.den = qd;
        st_nxt = S_CY;
      end
      S_CY: if (ddone) begin tx_nxt = tdiv; ya = ylo_r; st_nxt = S_CYW; end
      S_CYW: begin gl_nxt = yrd_r; ya = ylo_r + YW'(1); st_nxt = S_DY; end
      S_DY: begin gh_nxt = yrd_r; st_nxt = S_DYW; end
      S_DYW: begin
        dreq.start = 1'b1; dreq.num = qn; dreq.den = qd;
        st_nxt = S_Z0;
      end
      S_Z0: if (ddone) begin
        ty_nxt = tdiv; za = zrow + ZW'(ylo_r); st_nxt = S_Z1;
      end
      S_Z1: begin za = zrow + ZW'(yp_r) + ZW'(ylo_r); c0_nxt = zrd_r; st_nxt = S_Z2; end
      S_Z2: begin za = zrow + ZW'(ylo_r) + ZW'(1); c1_nxt = zrd_r; st_nxt = S_Z3; end
      S_Z3: begin
        za = zrow + ZW'(yp_r) + ZW'(ylo_r) + ZW'(1); c2_nxt = zrd_r; st_nxt = S_Z4;
      end
      S_Z4: begin c3_nxt = zrd_r; st_nxt = S_B1; end
      S_B1: begin r1_nxt = bres; st_nxt = S_B2; end
      S_B2: begin r2_nxt = bres; st_nxt = S_B3; end
      S_B3: begin
        res_nxt.interp_value = bres; res_nxt.in_range = 1'b1;
        strobe_nxt = 1'b1; st_nxt = S_IDLE;
      end
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // qn is 33 bits; dividend of the divider is qn<<16 handled by 16 shifts
  bgi_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; strobe_r <= 1'b0;
    end else begin
      st_r <= st_nxt; strobe_r <= strobe_nxt;
    end
    if (st_r == S_IDLE && start) req_r <= in_req;
    xlo_r <= xlo_nxt; xhi_r <= xhi_nxt; ylo_r <= ylo_nxt; yhi_r <= yhi_nxt;
    gl_r <= gl_nxt; gh_r <= gh_nxt; oor_r <= oor_nxt;
    c0_r <= c0_nxt; c1_r <= c1_nxt; c2_r <= c2_nxt; c3_r <= c3_nxt;
    r1_r <= r1_nxt; r2_r <= r2_nxt; tx_r <= tx_nxt; ty_r <= ty_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_OUT && req_r.op == OP_WX && req_r.entry_index < 12'(MAX_X_POINTS))
      xg[XW'(req_r.entry_index)] <= req_r.entry_value;
    xrd_r <= xg[xa];
  end
  always_ff @(posedge clk) begin
    if (st_r == S_OUT && req_r.op == OP_WY && req_r.entry_index < 12'(MAX_Y_POINTS))
      yg[YW'(req_r.entry_index)] <= req_r.entry_value;
    yrd_r <= yg[ya];
  end
  always_ff @(posedge clk) begin
    if (st_r == S_OUT && req_r.op == OP_WZ &&
        {1'b0, req_r.entry_index} < 13'(MAX_X_POINTS*MAX_Y_POINTS))
      zt[ZW'(req_r.entry_index)] <= req_r.entry_value;
    zrd_r <= zt[za];
  end

  assign busy = (st_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_res = res_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> st_r == S_IDLE) else $error("strobe while busy");
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !res_r.in_range) |-> res_r.interp_value == '0)
    else $error("nonzero outside grid");
  a_weights: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_B1 |-> (tx_r <= 17'h10000 && ty_r <= 17'h10000))
    else $error("weight above one");
  a_search: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CX |-> xlo_r <= XW'(xp_r - PW'(2))) else $error("cell out of range");
endmodule

// ===== dv/tb.sv =====
// Testbench for bilinear_grid_interpolator: random grids, writes and queries checked against a predictor.
module tb;
  import bgi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  bgi_in_t        in_req = '0;
  logic           out_strobe;
  bgi_out_t       out_res;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [0:0]     cfg_index = '0;
  logic [PW-1:0]  cfg_data = '0;

  bilinear_grid_interpolator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bgi_in_t     req_q[$];
  bgi_out_t    interp_q[$];
  int          errors = 0;
  bit          steady = 0;

  // predictor copy of the block state
  logic signed [31:0] px [MAX_X_POINTS];
  logic signed [31:0] py [MAX_Y_POINTS];
  logic signed [31:0] pz [MAX_X_POINTS*MAX_Y_POINTS];
  int                 pnx = MAX_X_POINTS, pny = MAX_Y_POINTS;

  // generator copy of the grids, to aim queries
  logic signed [31:0] gx [MAX_X_POINTS];
  logic signed [31:0] gy [MAX_Y_POINTS];
  int                 gnx = MAX_X_POINTS, gny = MAX_Y_POINTS;
  bit                 zw [MAX_X_POINTS*MAX_Y_POINTS];

  function automatic int clamp_pts(logic [PW-1:0] v, int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int locate_cell(bit is_x, int n, longint q);
    int lo, hi, mid;
    longint g;
    lo = 0;
    hi = n - 2;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      g = is_x ? longint'(px[mid]) : longint'(py[mid]);
      if (g <= q) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint cell_weight(longint lo, longint hi, longint q);
    longint d, num;
    d = hi - lo;
    num = q - lo;
    if (d <= 0 || num <= 0) return 0;
    if (num >= d) return 65536;
    return longint'((longint'(unsigned'(num)) << 16) / d);
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    return ((65536 - t) * a + t * b) >>> 16;
  endfunction

  function automatic void apply_request(bgi_in_t r);
    longint   qx, qy, tx, ty, r1, r2;
    int       i, j;
    bgi_out_t o;
    case (r.op)
      OP_WX: if (r.entry_index < MAX_X_POINTS) px[r.entry_index] = r.entry_value;
      OP_WY: if (r.entry_index < MAX_Y_POINTS) py[r.entry_index] = r.entry_value;
      OP_WZ: pz[r.entry_index] = r.entry_value;
      default: begin
        qx = r.query_x;
        qy = r.query_y;
        o = '0;
        if (!(qx < px[0] || qx > px[pnx-1] || qy < py[0] || qy > py[pny-1])) begin
          i = locate_cell(1, pnx, qx);
          j = locate_cell(0, pny, qy);
          tx = cell_weight(px[i], px[i+1], qx);
          ty = cell_weight(py[j], py[j+1], qy);
          r1 = lerp(pz[i*pny+j], pz[(i+1)*pny+j], tx);
          r2 = lerp(pz[i*pny+j+1], pz[(i+1)*pny+j+1], tx);
          o.interp_value = 32'(lerp(r1, r2, ty));
          o.in_range = 1'b1;
        end
        interp_q.push_back(o);
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_request(in_req);
      if (!start || !busy) begin
        if (req_q.size() > 0 && (steady || $urandom_range(99) >= 24)) begin
          in_req <= req_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (interp_q.size() == 0) begin
        $error("unexpected result: interp_value %0d in_range %0b",
               out_res.interp_value, out_res.in_range);
        errors++;
      end else begin
        bgi_out_t e;
        e = interp_q.pop_front();
        if (out_res.interp_value !== e.interp_value) begin
          $error("interp_value: expected %0d actual %0d", e.interp_value,
                 out_res.interp_value);
          errors++;
        end
        if (out_res.in_range !== e.in_range) begin
          $error("in_range: expected %0b actual %0b", e.in_range, out_res.in_range);
          errors++;
        end
      end
    end
  end

  task automatic push_write(logic [1:0] op, int idx, logic [31:0] val);
    bgi_in_t r;
    r = '0;
    r.op = op;
    r.entry_index = idx[11:0];
    r.entry_value = val;
    r.query_x = $urandom;
    r.query_y = $urandom;
    req_q.push_back(r);
    if (op == OP_WX && idx < MAX_X_POINTS) gx[idx] = val;
    if (op == OP_WY && idx < MAX_Y_POINTS) gy[idx] = val;
    if (op == OP_WZ && idx < MAX_X_POINTS * MAX_Y_POINTS) zw[idx] = 1'b1;
  endtask

  function automatic int aim_cell(bit is_x, longint q);
    int lo, hi, mid;
    longint g;
    lo = 0;
    hi = (is_x ? gnx : gny) - 2;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      g = is_x ? longint'(gx[mid]) : longint'(gy[mid]);
      if (g <= q) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // writes the corners of the query's cell that were never written, then queues the query
  task automatic push_query(logic [31:0] x, logic [31:0] y);
    bgi_in_t r;
    longint qx, qy;
    int i, j;
    int zi [4];
    qx = longint'(signed'(x));
    qy = longint'(signed'(y));
    if (!(qx < gx[0] || qx > gx[gnx-1] || qy < gy[0] || qy > gy[gny-1])) begin
      i = aim_cell(1, qx);
      j = aim_cell(0, qy);
      zi = '{i*gny+j, (i+1)*gny+j, i*gny+j+1, (i+1)*gny+j+1};
      foreach (zi[k]) if (!zw[zi[k]]) push_write(OP_WZ, zi[k], $urandom);
    end
    r.op = OP_Q;
    r.entry_index = 12'($urandom);
    r.entry_value = $urandom;
    r.query_x = x;
    r.query_y = y;
    req_q.push_back(r);
  endtask

  task automatic fill_axis(logic [1:0] op, int n, bit wide);
    longint lo, hi, step, v;
    logic [31:0] prev;
    if (wide) begin
      lo = -64'sd2147483648;
      hi = 64'sd2147483647;
    end else begin
      lo = longint'($urandom_range(2097152)) - 1048576;
      hi = lo + n + longint'($urandom_range(16777216));
    end
    step = (hi - lo) / (n - 1);
    for (int k = 0; k < n; k++) begin
      v = (k == n - 1) ? hi : lo + step * k;
      if (k > 0 && k < n - 1 && step >= 8)
        v += longint'($urandom_range(32'(step / 2))) - step / 4;
      if (k > 0 && k < n - 1 && $urandom_range(19) == 0) v = prev;
      prev = 32'(v);
      push_write(op, k, prev);
    end
  endtask

  function automatic logic [31:0] aim(bit is_x);
    longint lo, hi;
    int n, k;
    n = is_x ? gnx : gny;
    lo = is_x ? gx[0] : gy[0];
    hi = is_x ? gx[n-1] : gy[n-1];
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        k = $urandom_range(n - 1);
        return is_x ? gx[k] : gy[k];
      end
      2: return 32'(hi);
      default: if (hi > lo) return 32'(lo + longint'(($urandom * (hi - lo)) >> 32));
               else return 32'(lo);
    endcase
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [PW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_XP) begin
      pnx = clamp_pts(val, MAX_X_POINTS);
      gnx = pnx;
    end else begin
      pny = clamp_pts(val, MAX_Y_POINTS);
      gny = pny;
    end
  endtask

  task automatic drain();
    while (req_q.size() > 0 || start || interp_q.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    logic [PW-1:0] xs [5] = '{7'd2, 7'd0, 7'd127, 7'd5, 7'd33};
    logic [PW-1:0] ys [5] = '{7'd2, 7'd1, 7'd3, 7'd17, 7'd64};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // grid sizes at their reset value
    steady = 1;
    fill_axis(OP_WX, MAX_X_POINTS, 0);
    fill_axis(OP_WY, MAX_Y_POINTS, 0);
    push_write(OP_WZ, 0, 32'h8000_0000);
    push_write(OP_WZ, 1, 32'h7fff_ffff);
    push_write(OP_WZ, MAX_Y_POINTS, 32'h7fff_ffff);
    push_write(OP_WZ, MAX_Y_POINTS + 1, 32'h8000_0000);

    // directed queries and writes
    push_query(gx[0], gy[0]);
    push_query(gx[63], gy[63]);
    push_query(gx[63], gy[0]);
    push_query(gx[0] - 1, gy[5]);
    push_query(gx[63] + 1, gy[5]);
    push_query(gx[5], gy[0] - 1);
    push_query(gx[5], gy[63] + 1);
    push_query(32'h8000_0000, 32'h8000_0000);
    push_query(32'h7fff_ffff, 32'h7fff_ffff);
    push_query(gx[5], gy[7]);
    push_query(gx[0] + (gx[1] - gx[0]) / 2, gy[0] + (gy[1] - gy[0]) / 2);
    push_query(gx[1] - 1, gy[1] - 1);
    push_write(OP_WX, 4095, 32'hffff_ffff);
    push_write(OP_WY, 64, 32'h0);
    push_write(OP_WZ, 4095, 32'h5555_aaaa);
    push_query(gx[62], gy[62] + 1);
    for (int k = 0; k < 6; k++) push_query(aim(1), aim(0));
    drain();
    steady = 0;

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_XP, xs[p]);
      write_reg(CFG_YP, ys[p]);
      if (gnx < 8) fill_axis(OP_WX, gnx, p == 0);
      if (gny < 8) fill_axis(OP_WY, gny, p == 1);
      for (int k = 0; k < 18; k++) begin
        case ($urandom_range(9))
          0: push_write(OP_WZ, $urandom_range(4095), $urandom);
          1: push_write($urandom_range(1) ? OP_WX : OP_WY, $urandom_range(4095),
                        $urandom);
          default: push_query(aim(1), aim(0));
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== bilinear_grid_interpolator.f =====
hdl/bgi_pkg.sv
hdl/bgi_div.sv
hdl/bilinear_grid_interpolator.sv
dv/tb.sv
